FILE: hdl/ramped_bangbang_actuator_drive_top_macros.svh
// Assertion macros used by the actuator drive top level.
`ifndef RAMPED_BANGBANG_ACTUATOR_DRIVE_TOP_MACROS_SVH
`define RAMPED_BANGBANG_ACTUATOR_DRIVE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RBAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rbad_pkg.sv
// Package with types and constants of the actuator drive.
`timescale 1ns / 1ps
package rbad_pkg;

    localparam int POS_W     = 16;
    localparam int DUTY_W    = 8;
    localparam int DIR_W     = 2;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    localparam logic [POS_W-1:0]  ELAPSED_MAX = 16'hFFFF;
    localparam logic [DUTY_W-1:0] DUTY_FULL   = 8'hFF;
    localparam logic [DUTY_W-1:0] DUTY_OFF    = 8'h00;

    typedef enum logic [0:0] {
        OP_TICK     = 1'b0,
        OP_SETPOINT = 1'b1
    } op_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_IDLE   = 2'd0,
        DIR_PULL   = 2'd1,
        DIR_LOOSEN = 2'd2
    } dir_t;

    typedef enum logic [DIR_W-1:0] {
        BRIDGE_OFF    = 2'd0,
        BRIDGE_PULL   = 2'd1,
        BRIDGE_LOOSEN = 2'd2
    } bridge_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_POSITION   = 3'd0,
        CFG_MAX_POSITION   = 3'd1,
        CFG_HOLD_BAND      = 3'd2,
        CFG_SLOW_BAND      = 3'd3,
        CFG_RAMP_PULL_MS   = 3'd4,
        CFG_RAMP_LOOSEN_MS = 3'd5,
        CFG_PULL_PROFILE   = 3'd6,
        CFG_LOOSEN_PROFILE = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DUTY_W-1:0] slow_duty;
        logic [7:0]        step;
        logic [7:0]        init;
    } profile_t;

    typedef struct packed {
        logic [POS_W-1:0] min_position;
        logic [POS_W-1:0] max_position;
        logic [POS_W-1:0] hold_band;
        logic [POS_W-1:0] slow_band;
        logic [POS_W-1:0] ramp_pull_ms;
        logic [POS_W-1:0] ramp_loosen_ms;
        profile_t         pull_profile;
        profile_t         loosen_profile;
    } cfg_t;

    typedef struct packed {
        dir_t              dir;
        bridge_t           bridge;
        logic [DUTY_W-1:0] duty;
    } result_t;

endpackage

FILE: hdl/rbad_cfg.sv
// Configuration register bank of the actuator drive.
`timescale 1ns / 1ps
module rbad_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rbad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbad_pkg::CFG_W-1:0]     cfg_wdata,
    output rbad_pkg::cfg_t                cfg
);
    import rbad_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_POSITION:   cfg_next.min_position   = cfg_wdata[POS_W-1:0];
                CFG_MAX_POSITION:   cfg_next.max_position   = cfg_wdata[POS_W-1:0];
                CFG_HOLD_BAND:      cfg_next.hold_band      = cfg_wdata[POS_W-1:0];
                CFG_SLOW_BAND:      cfg_next.slow_band      = cfg_wdata[POS_W-1:0];
                CFG_RAMP_PULL_MS:   cfg_next.ramp_pull_ms   = cfg_wdata[POS_W-1:0];
                CFG_RAMP_LOOSEN_MS: cfg_next.ramp_loosen_ms = cfg_wdata[POS_W-1:0];
                CFG_PULL_PROFILE:   cfg_next.pull_profile   = profile_t'(cfg_wdata);
                CFG_LOOSEN_PROFILE: cfg_next.loosen_profile = profile_t'(cfg_wdata);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_position   <= 16'd0;
            cfg_reg.max_position   <= 16'd65535;
            cfg_reg.hold_band      <= 16'd16;
            cfg_reg.slow_band      <= 16'd256;
            cfg_reg.ramp_pull_ms   <= 16'd500;
            cfg_reg.ramp_loosen_ms <= 16'd500;
            cfg_reg.pull_profile   <= '0;
            cfg_reg.loosen_profile <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/rbad_core.sv
// Drive state and the single-pass update logic for one request.
`timescale 1ns / 1ps
module rbad_core #(
    parameter int CYCLE_MS = 50
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  rbad_pkg::op_t             opcode,
    input  logic [rbad_pkg::POS_W-1:0] position,
    input  logic [rbad_pkg::POS_W-1:0] setpoint,
    input  rbad_pkg::cfg_t            cfg,
    output rbad_pkg::result_t         res_next
);
    import rbad_pkg::*;

    localparam int CPOS_W = $clog2(CYCLE_MS + 1);
    localparam int CNUM_W = $clog2(65535 / CYCLE_MS + 1);
    localparam int THR_W  = CNUM_W + 9;
    localparam logic [CPOS_W-1:0] CPOS_LAST = CPOS_W'(CYCLE_MS - 1);

    dir_t              dir_reg, dir_next;
    bridge_t           bridge_reg, bridge_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [POS_W-1:0]  target_reg, target_next;
    logic [POS_W-1:0]  elapsed_reg, elapsed_next;
    logic [CPOS_W-1:0] cpos_reg, cpos_next;
    logic [CNUM_W-1:0] cnum_reg, cnum_next;

    logic [POS_W-1:0]  sp_lo, sp_c, sp_err, tk_err, ramp_len;
    profile_t          prof;
    logic [THR_W-1:0]  thr;
    logic              off_phase;

    function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign sp_lo  = (setpoint < cfg.min_position) ? cfg.min_position : setpoint;
    assign sp_c   = (sp_lo > cfg.max_position) ? cfg.max_position : sp_lo;
    assign sp_err = abs_diff(position, sp_c);
    assign tk_err = abs_diff(position, target_reg);

    assign prof     = (dir_reg == DIR_PULL) ? cfg.pull_profile : cfg.loosen_profile;
    assign ramp_len = (dir_reg == DIR_PULL) ? cfg.ramp_pull_ms : cfg.ramp_loosen_ms;
    assign thr      = THR_W'(prof.init) + THR_W'(cnum_reg) * THR_W'(prof.step);
    assign off_phase = (elapsed_reg <= ramp_len) && (THR_W'(cpos_reg) > thr);

    always_comb
    begin
        dir_next     = dir_reg;
        bridge_next  = bridge_reg;
        duty_next    = duty_reg;
        target_next  = target_reg;
        elapsed_next = elapsed_reg;
        cpos_next    = cpos_reg;
        cnum_next    = cnum_reg;
        if (en)
        begin
            unique case (opcode)
                OP_SETPOINT:
                begin
                    target_next = sp_c;
                    if (sp_err < cfg.hold_band)
                    begin
                        duty_next = DUTY_OFF;
                    end
                    else if (!((sp_c > position && dir_reg == DIR_PULL) ||
                               (sp_c < position && dir_reg == DIR_LOOSEN)))
                    begin
                        dir_next     = (sp_c < position) ? DIR_LOOSEN : DIR_PULL;
                        elapsed_next = '0;
                        cpos_next    = '0;
                        cnum_next    = '0;
                    end
                end
                OP_TICK:
                begin
                    if (elapsed_reg != ELAPSED_MAX)
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                        if (cpos_reg == CPOS_LAST)
                        begin
                            cpos_next = '0;
                            cnum_next = cnum_reg + 1'b1;
                        end
                        else
                        begin
                            cpos_next = cpos_reg + 1'b1;
                        end
                    end
                    if (dir_reg != DIR_IDLE)
                    begin
                        if (tk_err < cfg.hold_band)
                        begin
                            duty_next = DUTY_OFF;
                        end
                        else
                        begin
                            bridge_next = (position < target_reg) ? BRIDGE_PULL
                                                                  : BRIDGE_LOOSEN;
                            if (off_phase)
                                duty_next = DUTY_OFF;
                            else if (tk_err > cfg.slow_band)
                                duty_next = DUTY_FULL;
                            else
                                duty_next = prof.slow_duty;
                        end
                    end
                end
                default:
                begin
                    duty_next = duty_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg     <= DIR_IDLE;
            bridge_reg  <= BRIDGE_OFF;
            duty_reg    <= DUTY_OFF;
            target_reg  <= '0;
            elapsed_reg <= '0;
            cpos_reg    <= '0;
            cnum_reg    <= '0;
        end
        else
        begin
            dir_reg     <= dir_next;
            bridge_reg  <= bridge_next;
            duty_reg    <= duty_next;
            target_reg  <= target_next;
            elapsed_reg <= elapsed_next;
            cpos_reg    <= cpos_next;
            cnum_reg    <= cnum_next;
        end
    end

    assign res_next.dir    = dir_next;
    assign res_next.bridge = bridge_next;
    assign res_next.duty   = duty_next;

endmodule

FILE: hdl/ramped_bangbang_actuator_drive_top.sv
// Top level of the ramped bang-bang actuator drive.
//
// The slave stream carries one request per transfer: a position sample and,
// when tuser is high, a new setpoint; with tuser low the request is a one
// millisecond tick. Every request yields exactly one result on the master
// stream: the motor duty, the bridge direction and the latched direction.
// Configuration registers must be written through cfg_we, cfg_index and
// cfg_wdata only while no request is in flight; the block does not enforce it.
// A request accepted into the input register is evaluated once the output
// register is empty or being read, and that evaluation loads its result into
// the output register, from which the result is offered on the master stream.
// One request is accepted every cycle while m_tready is high; the ramp cycle
// position and cycle number are kept as counters, so the tick path holds one
// multiply of the cycle number by the 8-bit step and a compare.
// When the receiver stalls, the result is held in the output register and
// the input register still takes one more request; s_tready falls only
// when both are full. Reset empties both registers, clears the drive state
// and returns the configuration to its defaults.
`timescale 1ns / 1ps
`include "ramped_bangbang_actuator_drive_top_macros.svh"
module ramped_bangbang_actuator_drive_top #(
    parameter int CYCLE_MS = 50
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rbad_pkg::IN_DATA_W-1:0]     s_tdata,  // position, setpoint
    input  logic                               s_tuser,  // opcode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rbad_pkg::OUT_DATA_W-1:0]    m_tdata,  // motor_duty, bridge_dir,
                                                         // moving_dir, zero fill
    input  logic                               cfg_we,
    input  logic [rbad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbad_pkg::CFG_W-1:0]         cfg_wdata
);
    import rbad_pkg::*;

    cfg_t              cfg;
    result_t           res_next;
    result_t           out_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    op_t               op_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  sp_reg;
    logic              advance;
    logic              s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = s_fire || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg  <= op_t'(s_tuser);
            pos_reg <= s_tdata[POS_W-1:0];
            sp_reg  <= s_tdata[2*POS_W-1:POS_W];
        end
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    rbad_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rbad_core #(
        .CYCLE_MS (CYCLE_MS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .opcode   (op_reg),
        .position (pos_reg),
        .setpoint (sp_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - DUTY_W - 2*DIR_W)'(0), out_reg};

    `RBAD_ASSERT_NOW(a_ready_low_only_when_full, clk, rst_n, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready, "input stalled without a full pipe")
    `RBAD_ASSERT_NOW(a_duty_needs_direction, clk, rst_n,
        out_valid_reg && (out_reg.duty != DUTY_OFF), out_reg.dir != DIR_IDLE,
        "motor driven while direction is idle")
    `RBAD_ASSERT_NEXT(a_advance_fills_output, clk, rst_n, advance, out_valid_reg,
        "evaluated request did not reach the output register")

endmodule
